// ----- rtl/rounded_rect_sdf_alpha_core_defines.svh -----
// assertion macros for the rounded rectangle alpha core checker
// depends on nothing; expects i_clk and i_rst_n in the including scope
`ifndef ROUNDED_RECT_SDF_ALPHA_CORE_DEFINES_SVH
`define ROUNDED_RECT_SDF_ALPHA_CORE_DEFINES_SVH

// consequent checked in the same cycle
`define RRSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define RRSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rrsa_pkg.sv -----
// shared types, widths and register codes for the rounded rectangle alpha core
// depends on nothing
package rrsa_pkg;

    localparam int PIX_W  = 12;
    localparam int DIM_W  = 13;
    localparam int RAD_W  = 12;
    localparam int COL_W  = 8;
    localparam int IDX_W  = 3;
    localparam int ADDR_W = IDX_W + 2;
    localparam int DATA_W = 32;

    localparam int FRAC_BITS_DEF = 8;
    localparam int MAX_DIM       = 4096;

    // saturation value for the size registers
    localparam logic [DIM_W-1:0] DIM_CAP =
        (MAX_DIM > (2**DIM_W - 1)) ? DIM_W'(2**DIM_W - 1) : DIM_W'(MAX_DIM);

    // half-pixel geometry widths
    localparam int Q_W   = DIM_W + 2;
    localparam int ABS_W = DIM_W + 1;
    localparam int SQ_W  = 2 * ABS_W;
    localparam int S_W   = SQ_W + 1;
    localparam int M_W   = DIM_W + 2;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH   = DIM_W'(64);
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT  = DIM_W'(64);
    localparam logic [RAD_W-1:0] RST_CORNER_RADIUS = '0;
    localparam logic [COL_W-1:0] RST_LEVEL         = '1;

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_CORNER_RADIUS = 3'd2,
        REG_RED_LEVEL     = 3'd3,
        REG_GREEN_LEVEL   = 3'd4,
        REG_BLUE_LEVEL    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0] img_w;
        logic [DIM_W-1:0] img_h;
        logic [RAD_W-1:0] radius;
    } t_geom_cfg;

    // travels beside the distance data down the pipe
    typedef struct packed {
        logic           zero;
        logic [M_W-1:0] m;
    } t_side;

endpackage

// ----- rtl/rounded_rect_sdf_alpha_core.sv -----
// rounded rectangle pixel generator: config registers, pipeline control, output buffer
// depends on rrsa_pkg, rrsa_geom, rrsa_isqrt, rrsa_cover
//
//  channel   direction  handshake                 word
//  ------    ---------  ------------------------  ---------------------------------
//  config    in/out     psel/penable/pwrite       32-bit register at byte addr 4*i
//  pixel     in         i_in_valid/o_in_ready     pixel_x, pixel_y
//  color     out        o_out_valid/i_out_ready   red_out, green_out, blue_out, alpha_out
//
// one word per cycle sustained while the output is not stalled; the square-root pipeline
// resolves one root bit per stage
// synchronous active-low reset clears the valid bits and restores register defaults
// a word arriving while the output is stalled moves into a one-word skid register, the pipe keeps accepting
// until the skid is full, then freezes as a whole and nothing is lost or repeated
module rounded_rect_sdf_alpha_core #(
    parameter int FRAC_BITS = rrsa_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rrsa_pkg::ADDR_W-1:0] paddr,
    input  logic [rrsa_pkg::DATA_W-1:0] pwdata,
    output logic [rrsa_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    // pixel words
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [rrsa_pkg::PIX_W-1:0]  i_pixel_x,
    input  logic [rrsa_pkg::PIX_W-1:0]  i_pixel_y,
    // color words
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rrsa_pkg::COL_W-1:0]  o_red_out,
    output logic [rrsa_pkg::COL_W-1:0]  o_green_out,
    output logic [rrsa_pkg::COL_W-1:0]  o_blue_out,
    output logic [rrsa_pkg::COL_W-1:0]  o_alpha_out
);
    import rrsa_pkg::*;

    localparam int RW = (S_W + 2*FRAC_BITS + 1) / 2;

    // config registers
    logic [DIM_W-1:0] r_image_width, r_image_height;
    logic [RAD_W-1:0] r_corner_radius;
    logic [COL_W-1:0] r_red_level, r_green_level, r_blue_level;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;

    // pipeline links
    logic             pipe_en;
    t_geom_cfg        geom_cfg;
    logic             geo_valid;
    logic [S_W-1:0]   geo_sum;
    t_side            geo_side;
    logic             sq_valid;
    logic [RW-1:0]    sq_root;
    t_side            sq_side;
    logic             cov_valid;
    logic [COL_W-1:0] cov_alpha;

    // output register and skid
    logic             r_out_valid, n_out_valid;
    logic [COL_W-1:0] r_out_alpha, n_out_alpha;
    logic             r_skid_valid, n_skid_valid;
    logic [COL_W-1:0] r_skid_alpha, n_skid_alpha;
    logic             out_pop;

    // ---------------------------------------------------------------- config port
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= RST_IMAGE_WIDTH;
            r_image_height  <= RST_IMAGE_HEIGHT;
            r_corner_radius <= RST_CORNER_RADIUS;
            r_red_level     <= RST_LEVEL;
            r_green_level   <= RST_LEVEL;
            r_blue_level    <= RST_LEVEL;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_IMAGE_WIDTH:   r_image_width   <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  r_image_height  <= pwdata[DIM_W-1:0];
                REG_CORNER_RADIUS: r_corner_radius <= pwdata[RAD_W-1:0];
                REG_RED_LEVEL:     r_red_level     <= pwdata[COL_W-1:0];
                REG_GREEN_LEVEL:   r_green_level   <= pwdata[COL_W-1:0];
                REG_BLUE_LEVEL:    r_blue_level    <= pwdata[COL_W-1:0];
                default: ;
            endcase
        end
    end

    // read back, unmapped addresses read zero
    always_comb begin
        case (cfg_idx)
            REG_IMAGE_WIDTH:   prdata = DATA_W'(r_image_width);
            REG_IMAGE_HEIGHT:  prdata = DATA_W'(r_image_height);
            REG_CORNER_RADIUS: prdata = DATA_W'(r_corner_radius);
            REG_RED_LEVEL:     prdata = DATA_W'(r_red_level);
            REG_GREEN_LEVEL:   prdata = DATA_W'(r_green_level);
            REG_BLUE_LEVEL:    prdata = DATA_W'(r_blue_level);
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- pipeline
    // the whole pipe advances while the skid register is empty; the skid takes
    // the one word that can arrive in the cycle the output stalls
    assign pipe_en    = !r_skid_valid;
    assign o_in_ready = pipe_en;

    assign geom_cfg.img_w  = r_image_width;
    assign geom_cfg.img_h  = r_image_height;
    assign geom_cfg.radius = r_corner_radius;

    // offsets, corner distances, squares, sum (4 stages)
    rrsa_geom u_geom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (pipe_en),
        .i_valid   (i_in_valid),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_cfg     (geom_cfg),
        .o_valid   (geo_valid),
        .o_sum     (geo_sum),
        .o_side    (geo_side)
    );

    // floor root of sum * 4^frac (RW stages)
    rrsa_isqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (geo_valid),
        .i_sum   (geo_sum),
        .i_side  (geo_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // coverage clamp and alpha (2 stages)
    rrsa_cover #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cover (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (sq_valid),
        .i_root  (sq_root),
        .i_side  (sq_side),
        .o_valid (cov_valid),
        .o_alpha (cov_alpha)
    );

    // ---------------------------------------------------------------- output buffer
    assign out_pop = r_out_valid && i_out_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_alpha  = r_out_alpha;
        n_skid_valid = r_skid_valid;
        n_skid_alpha = r_skid_alpha;
        if (r_skid_valid) begin
            // pipe frozen, drain skid into the output slot
            if (out_pop) begin
                n_out_alpha  = r_skid_alpha;
                n_skid_valid = 1'b0;
            end
        end else if (cov_valid) begin
            if (!r_out_valid || out_pop) begin
                n_out_valid = 1'b1;
                n_out_alpha = cov_alpha;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_alpha = cov_alpha;
            end
        end else if (out_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_alpha  <= n_out_alpha;
        r_skid_alpha <= n_skid_alpha;
    end

    // colors ride straight from the registers; the user must change them only while idle (unchecked)
    assign o_out_valid = r_out_valid;
    assign o_alpha_out = r_out_alpha;
    assign o_red_out   = r_red_level;
    assign o_green_out = r_green_level;
    assign o_blue_out  = r_blue_level;

endmodule

// ----- rtl/rrsa_geom.sv -----
// geometry front end: half-pixel offsets, box distances and squared outside distance
// depends on rrsa_pkg
module rrsa_geom (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [rrsa_pkg::PIX_W-1:0] i_pixel_x,
    input  logic [rrsa_pkg::PIX_W-1:0] i_pixel_y,
    input  rrsa_pkg::t_geom_cfg        i_cfg,
    output logic                       o_valid,
    output logic [rrsa_pkg::S_W-1:0]   o_sum,
    output rrsa_pkg::t_side            o_side
);
    import rrsa_pkg::*;

    logic [DIM_W-1:0]        w_eff, h_eff, r2_dbl, r2;
    logic signed [Q_W-1:0]   px2, py2, px2_neg, py2_neg;
    logic signed [Q_W-1:0]   qx, qy, q_min, inner;
    logic signed [Q_W:0]     m_full;

    logic                    r_v1, r_v2, r_v3, r_v4;
    logic [ABS_W-1:0]        r_apx, r_apy;
    logic [DIM_W-1:0]        r_wr, r_hr, r_r2;
    logic                    r_zero1;
    logic [ABS_W-1:0]        r_ox, r_oy, n_ox, n_oy;
    t_side                   r_side2, r_side3, r_side4, n_side2;
    logic [SQ_W-1:0]         r_sqx, r_sqy;
    logic [S_W-1:0]          r_sum;

    // stage 1: clamp sizes, radius, offsets from the center
    always_comb begin
        w_eff   = (i_cfg.img_w > DIM_CAP) ? DIM_CAP : i_cfg.img_w;
        h_eff   = (i_cfg.img_h > DIM_CAP) ? DIM_CAP : i_cfg.img_h;
        r2_dbl  = {i_cfg.radius, 1'b0};
        r2      = r2_dbl;
        if (r2 > w_eff) begin
            r2 = w_eff;
        end
        if (r2 > h_eff) begin
            r2 = h_eff;
        end
        px2     = $signed({2'b00, i_pixel_x, 1'b1}) - $signed({2'b00, w_eff});
        py2     = $signed({2'b00, i_pixel_y, 1'b1}) - $signed({2'b00, h_eff});
        px2_neg = -px2;
        py2_neg = -py2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_apx   <= px2[Q_W-1] ? px2_neg[ABS_W-1:0] : px2[ABS_W-1:0];
            r_apy   <= py2[Q_W-1] ? py2_neg[ABS_W-1:0] : py2[ABS_W-1:0];
            r_wr    <= w_eff - r2;
            r_hr    <= h_eff - r2;
            r_r2    <= r2;
            r_zero1 <= (i_cfg.img_w == '0) || (i_cfg.img_h == '0);
        end
    end

    // stage 2: corner-relative distances
    always_comb begin
        qx     = $signed({1'b0, r_apx}) - $signed({2'b00, r_wr});
        qy     = $signed({1'b0, r_apy}) - $signed({2'b00, r_hr});
        n_ox   = (!qx[Q_W-1] && (qx != '0)) ? qx[ABS_W-1:0] : '0;
        n_oy   = (!qy[Q_W-1] && (qy != '0)) ? qy[ABS_W-1:0] : '0;
        q_min  = (qx < qy) ? qx : qy;
        inner  = q_min[Q_W-1] ? q_min : '0;
        m_full = $signed({3'b000, r_r2}) - $signed({inner[Q_W-1], inner});
        n_side2.zero = r_zero1;
        n_side2.m    = m_full[M_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ox    <= n_ox;
            r_oy    <= n_oy;
            r_side2 <= n_side2;
        end
    end

    // stage 3: squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx   <= r_ox * r_ox;
            r_sqy   <= r_oy * r_oy;
            r_side3 <= r_side2;
        end
    end

    // stage 4: sum of squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum   <= {1'b0, r_sqx} + {1'b0, r_sqy};
            r_side4 <= r_side3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_valid = r_v4;
    assign o_sum   = r_sum;
    assign o_side  = r_side4;

endmodule

// ----- rtl/rrsa_isqrt.sv -----
// pipelined floor square root of the scaled sum of squares, one root bit per stage
// depends on rrsa_pkg
module rrsa_isqrt #(
    parameter int FRAC_BITS = rrsa_pkg::FRAC_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_valid,
    input  logic [rrsa_pkg::S_W-1:0]                      i_sum,
    input  rrsa_pkg::t_side                               i_side,
    output logic                                          o_valid,
    output logic [(rrsa_pkg::S_W + 2*FRAC_BITS + 1)/2-1:0] o_root,
    output rrsa_pkg::t_side                               o_side
);
    import rrsa_pkg::*;

    localparam int RW   = (S_W + 2*FRAC_BITS + 1) / 2;
    localparam int RADW = 2 * RW;
    localparam int REMW = RW + 2;

    logic [RW-1:0]   r_v;
    logic [REMW-1:0] r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [RADW-1:0] r_rad  [RW];
    t_side           r_side [RW];

    logic [REMW-1:0] a_rem  [RW];
    logic [RW-1:0]   a_root [RW];
    logic [RADW-1:0] a_rad  [RW];
    t_side           a_side [RW];

    logic [REMW-1:0] cur    [RW];
    logic [REMW-1:0] trial  [RW];
    logic [REMW-1:0] n_rem  [RW];
    logic [RW-1:0]   n_root [RW];

    // stage inputs: first stage from the port, the rest from the stage before
    always_comb begin
        a_rem[0]  = '0;
        a_root[0] = '0;
        a_rad[0]  = RADW'({i_sum, {(2*FRAC_BITS){1'b0}}});
        a_side[0] = i_side;
        for (int k = 1; k < RW; k++) begin
            a_rem[k]  = r_rem[k-1];
            a_root[k] = r_root[k-1];
            a_rad[k]  = r_rad[k-1];
            a_side[k] = r_side[k-1];
        end
    end

    // one restoring step per stage, each stage independent
    always_comb begin
        for (int k = 0; k < RW; k++) begin
            cur[k]   = {a_rem[k][REMW-3:0], a_rad[k][RADW-1:RADW-2]};
            trial[k] = {a_root[k], 2'b01};
            if (cur[k] >= trial[k]) begin
                n_rem[k]  = cur[k] - trial[k];
                n_root[k] = {a_root[k][RW-2:0], 1'b1};
            end else begin
                n_rem[k]  = cur[k];
                n_root[k] = {a_root[k][RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= {a_rad[k][RADW-3:0], 2'b00};
                r_side[k] <= a_side[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[RW-2:0], i_valid};
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

// ----- rtl/rrsa_cover.sv -----
// coverage clamp and alpha scaling, two stages
// depends on rrsa_pkg
module rrsa_cover #(
    parameter int FRAC_BITS = rrsa_pkg::FRAC_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_valid,
    input  logic [(rrsa_pkg::S_W + 2*FRAC_BITS + 1)/2-1:0] i_root,
    input  rrsa_pkg::t_side                               i_side,
    output logic                                          o_valid,
    output logic [rrsa_pkg::COL_W-1:0]                    o_alpha
);
    import rrsa_pkg::*;

    localparam int RW = (S_W + 2*FRAC_BITS + 1) / 2;
    localparam int TW = M_W + FRAC_BITS;
    localparam int DW = ((TW > RW) ? TW : RW) + 1;
    localparam int CW = FRAC_BITS + 2;
    localparam logic [DW-2:0] C2_MAX = (DW-1)'(1) << (FRAC_BITS + 1);

    logic [M_W-1:0]       m_inc;
    logic [TW-1:0]        t_scaled;
    logic signed [DW-1:0] diff;
    logic [CW-1:0]        n_c2;
    logic [CW+COL_W-1:0]  prod;

    logic                 r_va, r_vb;
    logic [CW-1:0]        r_c2;
    logic                 r_zero;
    logic [COL_W-1:0]     r_alpha;

    // doubled coverage: (m + 1) * 2^f - root, clamped to [0, 2^(f+1)]
    always_comb begin
        m_inc    = i_side.m + M_W'(1);
        t_scaled = {m_inc, {FRAC_BITS{1'b0}}};
        diff     = $signed(DW'(t_scaled)) - $signed(DW'(i_root));
        if (diff[DW-1]) begin
            n_c2 = '0;
        end else if (diff[DW-2:0] > C2_MAX) begin
            n_c2 = C2_MAX[CW-1:0];
        end else begin
            n_c2 = diff[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c2   <= n_c2;
            r_zero <= i_side.zero;
        end
    end

    // times 255 as shift minus value, then drop f+1 bits
    assign prod = {r_c2, {COL_W{1'b0}}} - {{COL_W{1'b0}}, r_c2};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_alpha <= r_zero ? '0 : prod[FRAC_BITS+COL_W:FRAC_BITS+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    assign o_valid = r_vb;
    assign o_alpha = r_alpha;

endmodule

// ----- rtl/rrsa_checker.sv -----
// port-level checks on the rounded rectangle alpha core, bound to the top level
// depends on rrsa_pkg and rounded_rect_sdf_alpha_core_defines.svh
`include "rounded_rect_sdf_alpha_core_defines.svh"

module rrsa_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [rrsa_pkg::COL_W-1:0] o_alpha_out
);

    // a stalled word stays offered
    `RRSA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "out word dropped")

    // and keeps its value
    `RRSA_ASSERT_NEXT(a_alpha_hold, o_out_valid && !i_out_ready, $stable(o_alpha_out), "alpha moved")

    // input backpressure only follows an output stall
    `RRSA_ASSERT_NOW(a_ready_cause, !o_in_ready, $past(o_out_valid && !i_out_ready), "no stall")

    // a full skid refills the output slot when it is taken
    `RRSA_ASSERT_NEXT(a_skid_drain, o_out_valid && i_out_ready && !o_in_ready, o_out_valid, "skid lost")

endmodule

bind rounded_rect_sdf_alpha_core rrsa_checker u_rrsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_alpha_out (o_alpha_out)
);
